[src/periodic_timer_bank_core_macros.svh]
// assertion helpers for the timer bank
`ifndef PERIODIC_TIMER_BANK_CORE_MACROS_SVH
`define PERIODIC_TIMER_BANK_CORE_MACROS_SVH

// same-cycle implication, sampled on clk_i, held off while rst_ni is low
`define PTB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[src/ptb_pkg.sv]
`timescale 1ns / 1ps

package ptb_pkg;

  localparam int unsigned NumSlotsDef = 16;

  localparam int unsigned KindW   = 3;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 32;

  localparam logic [KindW-1:0] KindTick    = 3'd0;
  localparam logic [KindW-1:0] KindAlloc   = 3'd1;
  localparam logic [KindW-1:0] KindRestart = 3'd2;
  localparam logic [KindW-1:0] KindClear   = 3'd3;
  localparam logic [KindW-1:0] KindPoll    = 3'd4;

  localparam logic [StatusW-1:0] StatOk     = 2'd0;
  localparam logic [StatusW-1:0] StatFull   = 2'd1;
  localparam logic [StatusW-1:0] StatNoSlot = 2'd2;

  localparam logic [CountW-1:0] WrapLimitRst = 32'hFFFF_FFFF;

  // one slot's counters as kept in the slot memory
  typedef struct packed {
    logic [CountW-1:0] tick;
    logic [CountW-1:0] last;
    logic [CountW-1:0] resid;
    logic [CountW-1:0] period;
  } slot_rec_t;

  // updated slot from the advance unit
  typedef struct packed {
    slot_rec_t rec;
    logic      wrapped;
    logic      fire;
  } adv_res_t;

endpackage

[src/ptb_mem.sv]
`timescale 1ns / 1ps

module ptb_mem import ptb_pkg::*; #(
  parameter int unsigned Depth = NumSlotsDef,
  parameter int unsigned IdxW  = 4
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  slot_rec_t       wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output slot_rec_t       rdata_o
);

  slot_rec_t mem_q [Depth];
  slot_rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/ptb_adv.sv]
`timescale 1ns / 1ps

// two-stage slot advance: clamp and increments, then distance compare
module ptb_adv import ptb_pkg::*; (
  input  logic              clk_i,
  input  logic              load_i,
  input  slot_rec_t         rec_i,
  input  logic              wrapped_i,
  input  logic [CountW-1:0] wrap_limit_i,
  output adv_res_t          res_o
);

  logic [CountW-1:0] tick_inc_q, resid_q, resid_inc_q, last_c_q, period_q;
  logic              below_q, wrapped_q;

  logic [CountW-1:0] sub, cmp_val;
  logic              hit;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tick_inc_q  <= rec_i.tick + CountW'(1);
      resid_q     <= rec_i.resid;
      resid_inc_q <= rec_i.resid + CountW'(1);
      last_c_q    <= (rec_i.last > wrap_limit_i) ? wrap_limit_i : rec_i.last;
      period_q    <= rec_i.period;
      below_q     <= rec_i.tick < wrap_limit_i;
      wrapped_q   <= wrapped_i;
    end
  end

  // one subtract and one compare are shared among the branches
  assign sub     = tick_inc_q - last_c_q;
  assign cmp_val = wrapped_q ? resid_inc_q : sub;
  assign hit     = cmp_val >= period_q;

  always_comb begin
    res_o.rec.period = period_q;
    res_o.rec.tick   = tick_inc_q;
    res_o.rec.last   = last_c_q;
    res_o.rec.resid  = resid_q;
    res_o.wrapped    = wrapped_q;
    res_o.fire       = 1'b0;
    if (wrapped_q) begin
      if (hit) begin
        res_o.rec.last  = tick_inc_q;
        res_o.rec.resid = '0;
        res_o.wrapped   = 1'b0;
        res_o.fire      = 1'b1;
      end else begin
        res_o.rec.resid = resid_inc_q;
      end
    end else if (below_q) begin
      if (hit) begin
        res_o.rec.last = tick_inc_q;
        res_o.fire     = 1'b1;
      end
    end else begin
      // counter at or past the limit: restart it and carry the distance covered
      res_o.rec.resid = sub;
      res_o.rec.tick  = '0;
      res_o.wrapped   = 1'b1;
    end
  end

endmodule

[src/periodic_timer_bank_core.sv]
`timescale 1ns / 1ps
// channel  direction  signals
// in       input      in_valid_i / in_ready_o : kind_i, slot_i, period_i
// out      output     out_valid_o / out_ready_i : assigned_slot_o, fired_o, status_o
// cfg      input      cfg_valid_i / cfg_ready_o : cfg_data_i (wrap limit)
//
// a tick takes each allocated slot in turn through the one slot memory read port
// and the shared two-stage advance unit
// restart is a read-modify-write of the slot memory
// no clearing pass after reset: a slot is written by its allocate before any read
// a finished word waits in the output register; the next word is taken meanwhile
// the cfg port is always ready

`include "periodic_timer_bank_core_macros.svh"

module periodic_timer_bank_core import ptb_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NumSlotsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [KindW-1:0]   kind_i,
  input  logic [SlotW-1:0]   slot_i,
  input  logic [CountW-1:0]  period_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SlotW-1:0]   assigned_slot_o,
  output logic               fired_o,
  output logic [StatusW-1:0] status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CountW-1:0]  cfg_data_i
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(NUM_SLOTS + 1);
  localparam logic [CntW-1:0] SlotsMax = CntW'(NUM_SLOTS);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SFetch = 3'd1;
  localparam logic [2:0] SCalc  = 3'd2;
  localparam logic [2:0] SWrite = 3'd3;
  localparam logic [2:0] SRst   = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic                 is_tick_q, is_tick_d;
  logic [IdxW-1:0]      scan_q, scan_d;
  logic [CntW-1:0]      slots_used_q, slots_used_d;
  logic [NUM_SLOTS-1:0] wrapped_q, wrapped_d;
  logic [NUM_SLOTS-1:0] fire_q, fire_d;
  logic [CountW-1:0]    wrap_limit_q;
  logic [SlotW-1:0]     res_slot_q, res_slot_d;
  logic                 res_fired_q, res_fired_d;
  logic [StatusW-1:0]   res_status_q, res_status_d;
  logic                 out_valid_q, out_valid_d;
  logic [SlotW-1:0]     out_slot_q, out_slot_d;
  logic                 out_fired_q, out_fired_d;
  logic [StatusW-1:0]   out_status_q, out_status_d;

  logic                 in_fire;
  logic [IdxW+3:0]      slot_ext, aslot_ext;
  logic [IdxW-1:0]      sidx, aidx;
  logic                 slot_ok, full, scan_last;

  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  slot_rec_t            mem_wdata, mem_rdata;
  logic                 adv_load;
  adv_res_t             adv_res;

  ptb_mem #(
    .Depth (NUM_SLOTS),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (scan_q),
    .rdata_o (mem_rdata)
  );

  ptb_adv u_adv (
    .clk_i        (clk_i),
    .load_i       (adv_load),
    .rec_i        (mem_rdata),
    .wrapped_i    (wrapped_q[scan_q]),
    .wrap_limit_i (wrap_limit_q),
    .res_o        (adv_res)
  );

  assign in_ready_o  = (state_q == SIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign slot_ext  = {{IdxW{1'b0}}, slot_i};
  assign sidx      = slot_ext[IdxW-1:0];
  assign slot_ok   = {{CntW{1'b0}}, slot_i} < {{SlotW{1'b0}}, slots_used_q};
  assign full      = (slots_used_q == SlotsMax);
  assign aidx      = slots_used_q[IdxW-1:0];
  assign aslot_ext = {4'b0000, aidx};
  assign scan_last = ((CntW'(scan_q) + CntW'(1)) == slots_used_q);

  always_comb begin
    state_d      = state_q;
    is_tick_d    = is_tick_q;
    scan_d       = scan_q;
    slots_used_d = slots_used_q;
    wrapped_d    = wrapped_q;
    fire_d       = fire_q;
    res_slot_d   = res_slot_q;
    res_fired_d  = res_fired_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_waddr    = scan_q;
    mem_wdata    = adv_res.rec;
    adv_load     = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_slot_d   = out_slot_q;
    out_fired_d  = out_fired_q;
    out_status_d = out_status_q;

    case (state_q)
      SIdle: begin
        if (in_fire) begin
          res_slot_d   = '0;
          res_fired_d  = 1'b0;
          res_status_d = StatOk;
          state_d      = SDone;
          case (kind_i)
            KindTick: begin
              is_tick_d = 1'b1;
              scan_d    = '0;
              if (slots_used_q != '0) begin
                state_d = SFetch;
              end
            end
            KindAlloc: begin
              if (full) begin
                res_status_d = StatFull;
              end else begin
                mem_we           = 1'b1;
                mem_waddr        = aidx;
                mem_wdata.tick   = '0;
                mem_wdata.last   = '0;
                mem_wdata.resid  = '0;
                mem_wdata.period = period_i;
                wrapped_d[aidx]  = 1'b0;
                fire_d[aidx]     = 1'b0;
                slots_used_d     = slots_used_q + CntW'(1);
                res_slot_d       = aslot_ext[SlotW-1:0];
              end
            end
            KindRestart: begin
              if (!slot_ok) begin
                res_status_d = StatNoSlot;
              end else begin
                fire_d[sidx] = 1'b0;
                scan_d       = sidx;
                is_tick_d    = 1'b0;
                state_d      = SFetch;
              end
            end
            KindClear: begin
              if (!slot_ok) begin
                res_status_d = StatNoSlot;
              end else begin
                fire_d[sidx] = 1'b0;
              end
            end
            KindPoll: begin
              if (!slot_ok) begin
                res_status_d = StatNoSlot;
              end else begin
                res_fired_d  = fire_q[sidx];
                fire_d[sidx] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      SFetch: begin
        state_d = is_tick_q ? SCalc : SRst;
      end
      SCalc: begin
        adv_load = 1'b1;
        state_d  = SWrite;
      end
      SWrite: begin
        mem_we            = 1'b1;
        wrapped_d[scan_q] = adv_res.wrapped;
        if (adv_res.fire) begin
          fire_d[scan_q] = 1'b1;
        end
        if (scan_last) begin
          state_d = SDone;
        end else begin
          scan_d  = scan_q + IdxW'(1);
          state_d = SFetch;
        end
      end
      SRst: begin
        // restart keeps the residual count and the period
        mem_we           = 1'b1;
        mem_wdata.tick   = '0;
        mem_wdata.last   = '0;
        mem_wdata.resid  = mem_rdata.resid;
        mem_wdata.period = mem_rdata.period;
        state_d          = SDone;
      end
      SDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_slot_d   = res_slot_q;
          out_fired_d  = res_fired_q;
          out_status_d = res_status_q;
          state_d      = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      is_tick_q    <= 1'b0;
      scan_q       <= '0;
      slots_used_q <= '0;
      wrapped_q    <= '0;
      fire_q       <= '0;
      wrap_limit_q <= WrapLimitRst;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      is_tick_q    <= is_tick_d;
      scan_q       <= scan_d;
      slots_used_q <= slots_used_d;
      wrapped_q    <= wrapped_d;
      fire_q       <= fire_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        wrap_limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_slot_q   <= res_slot_d;
    res_fired_q  <= res_fired_d;
    res_status_q <= res_status_d;
    out_slot_q   <= out_slot_d;
    out_fired_q  <= out_fired_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o     = out_valid_q;
  assign assigned_slot_o = out_slot_q;
  assign fired_o         = out_fired_q;
  assign status_o        = out_status_q;

  `PTB_ASSERT_NOW(a_used_bound, 1'b1, slots_used_q <= SlotsMax, "slot count beyond bank size")
  `PTB_ASSERT_NOW(a_scan_alloc, (state_q == SCalc) || (state_q == SWrite), CntW'(scan_q) < slots_used_q, "advance on unallocated slot")
  `PTB_ASSERT_NOW(a_mem_write, mem_we, (state_q == SWrite) || (state_q == SRst) || (in_fire && (kind_i == KindAlloc) && !full), "slot memory written outside update")
  `PTB_ASSERT_NEXT(a_done_out, (state_q == SDone) && (!out_valid_q || out_ready_i), out_valid_q && (state_q == SIdle), "finished word not presented")

endmodule

[sim/periodic_timer_bank_core_tb.sv]
`timescale 1ns / 1ps

module periodic_timer_bank_core_tb;
  import ptb_pkg::*;

  localparam int unsigned Slots         = NumSlotsDef;
  localparam int unsigned TickCycles    = 3 * Slots + 2;
  localparam int unsigned HoldCycles    = 600;
  localparam int unsigned HoldAfter     = 250;
  localparam int unsigned ItemsPerPhase = 130;
  localparam int unsigned NumPhases     = 6;

  localparam logic [KindW-1:0] KindBadLo = KindPoll + 3'd1;
  localparam logic [KindW-1:0] KindBadHi = '1;

  typedef struct packed {
    logic [SlotW-1:0]   assigned;
    logic               fired;
    logic [StatusW-1:0] status;
  } reply_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] period;
    logic              typed;
    reply_t            reply;
  } timer_word_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [KindW-1:0]   kind_i;
  logic [SlotW-1:0]   slot_i;
  logic [CountW-1:0]  period_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [SlotW-1:0]   assigned_slot_o;
  logic               fired_o;
  logic [StatusW-1:0] status_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CountW-1:0]  cfg_data_i;

  periodic_timer_bank_core #(
    .NUM_SLOTS(Slots)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .slot_i         (slot_i),
    .period_i       (period_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .assigned_slot_o(assigned_slot_o),
    .fired_o        (fired_o),
    .status_o       (status_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // timer bank as the testbench sees it
  logic [CountW-1:0] tm_tick   [Slots];
  logic [CountW-1:0] tm_last   [Slots];
  logic [CountW-1:0] tm_resid  [Slots];
  logic [CountW-1:0] tm_period [Slots];
  logic              tm_wrapped[Slots];
  logic              tm_flag   [Slots];
  int unsigned       tm_used;
  logic [CountW-1:0] tm_wrap_limit;

  reply_t      pending_replies[$];
  int unsigned mismatches;
  int unsigned replies_seen;
  int unsigned words_sent;
  int unsigned fired_polls;
  int unsigned full_hits;
  int unsigned noslot_hits;
  int unsigned wrap_events;
  bit          no_idle;

  function automatic void advance_timer(int unsigned i);
    logic [CountW-1:0] since;
    if (tm_last[i] > tm_wrap_limit) tm_last[i] = tm_wrap_limit;
    if (tm_wrapped[i]) begin
      tm_tick[i]  = tm_tick[i] + 1'b1;
      tm_resid[i] = tm_resid[i] + 1'b1;
      if (tm_resid[i] >= tm_period[i]) begin
        tm_flag[i]    = 1'b1;
        tm_last[i]    = tm_tick[i];
        tm_wrapped[i] = 1'b0;
        tm_resid[i]   = '0;
      end
    end else if (tm_tick[i] < tm_wrap_limit) begin
      tm_tick[i] = tm_tick[i] + 1'b1;
      since      = tm_tick[i] - tm_last[i];
      if (since >= tm_period[i]) begin
        tm_flag[i] = 1'b1;
        tm_last[i] = tm_tick[i];
      end
    end else begin
      // distance covered so far carries over past the wrap
      tm_resid[i]   = tm_tick[i] + 1'b1 - tm_last[i];
      tm_tick[i]    = '0;
      tm_wrapped[i] = 1'b1;
      wrap_events++;
    end
  endfunction

  function automatic reply_t predict_reply(logic [KindW-1:0] kind, logic [SlotW-1:0] slot,
                                           logic [CountW-1:0] period);
    reply_t      r;
    int unsigned i;
    r = '0;
    case (kind)
      KindTick: begin
        for (i = 0; i < tm_used; i++) advance_timer(i);
      end
      KindAlloc: begin
        if (tm_used >= Slots) begin
          r.status = StatFull;
          full_hits++;
        end else begin
          i = tm_used;
          tm_used++;
          tm_tick[i]    = '0;
          tm_last[i]    = '0;
          tm_resid[i]   = '0;
          tm_period[i]  = period;
          tm_wrapped[i] = 1'b0;
          tm_flag[i]    = 1'b0;
          r.assigned    = SlotW'(i);
        end
      end
      KindRestart, KindClear, KindPoll: begin
        if (slot >= tm_used) begin
          r.status = StatNoSlot;
          noslot_hits++;
        end else if (kind == KindRestart) begin
          // wrap state survives a restart
          tm_tick[slot] = '0;
          tm_last[slot] = '0;
          tm_flag[slot] = 1'b0;
        end else if (kind == KindClear) begin
          tm_flag[slot] = 1'b0;
        end else begin
          r.fired       = tm_flag[slot];
          tm_flag[slot] = 1'b0;
          if (r.fired) fired_polls++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic timer_word_t mk_row(logic [KindW-1:0] k, logic [SlotW-1:0] s,
                                         logic [CountW-1:0] p, logic t,
                                         logic [SlotW-1:0] a, logic f,
                                         logic [StatusW-1:0] st);
    timer_word_t w;
    w.kind           = k;
    w.slot           = s;
    w.period         = p;
    w.typed          = t;
    w.reply.assigned = a;
    w.reply.fired    = f;
    w.reply.status   = st;
    return w;
  endfunction

  function automatic timer_word_t random_word();
    timer_word_t w;
    int unsigned r;
    w = '0;
    r = $urandom_range(0, 99);
    if (r < 35) w.kind = KindTick;
    else if (r < 43) w.kind = KindAlloc;
    else if (r < 51) w.kind = KindRestart;
    else if (r < 61) w.kind = KindClear;
    else if (r < 95) w.kind = KindPoll;
    else w.kind = KindW'($urandom_range(KindBadLo, KindBadHi));
    // mostly aim at slots already in use
    if (tm_used != 0 && $urandom_range(0, 9) < 7) w.slot = SlotW'($urandom_range(0, tm_used - 1));
    else w.slot = SlotW'($urandom());
    r = $urandom_range(0, 9);
    if (r < 4) w.period = CountW'($urandom_range(0, 3));
    else if (r < 8) w.period = CountW'($urandom_range(4, 30));
    else if (r < 9) w.period = CountW'($urandom());
    else w.period = {CountW{1'b1}} - CountW'($urandom_range(0, 3));
    return w;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input timer_word_t w);
    reply_t want;
    in_valid_i <= 1'b1;
    kind_i     <= w.kind;
    slot_i     <= w.slot;
    period_i   <= w.period;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    want = predict_reply(w.kind, w.slot, w.period);
    if (w.typed) want = w.reply;
    pending_replies.push_back(want);
    words_sent++;
  endtask

  task automatic idle_in(int unsigned n);
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    idle_in(1);
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (TickCycles) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(64'd6_000_000);
    $display("FAILED: results differ");
    $finish;
  end

  // receiving side: checks each word and stalls at random
  initial begin : rx_side
    reply_t      want;
    reply_t      got;
    int unsigned hold;
    int unsigned cyc;
    bit          held;
    bit          calm;
    int unsigned r;
    out_ready_i = 1'b0;
    hold = 0;
    cyc  = 0;
    held = 1'b0;
    calm = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = {assigned_slot_o, fired_o, status_o};
        if (pending_replies.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] reply word with nothing pending: slot %0d fired %0d status %0d",
                     $realtime, got.assigned, got.fired, got.status);
          mismatches++;
        end else begin
          want = pending_replies.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("[%0t] reply %0d: expected slot %0d fired %0d status %0d, got %0d %0d %0d",
                       $realtime, replies_seen, want.assigned, want.fired, want.status,
                       got.assigned, got.fired, got.status);
            mismatches++;
          end
          replies_seen++;
        end
      end
      if (cyc % 256 == 0) calm = ($urandom_range(0, 3) == 0);
      // one long hold-off so the input side backs up
      if (!held && replies_seen == HoldAfter) begin
        hold = HoldCycles;
        held = 1'b1;
      end
      if (hold != 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (calm || $urandom_range(0, 99) < 75) begin
        out_ready_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 9);
        if (r < 6) hold = $urandom_range(0, 1);
        else if (r < 9) hold = $urandom_range(2, 9);
        else hold = $urandom_range(19, 59);
        out_ready_i <= 1'b0;
      end
    end
  end

  initial begin : tx_side
    timer_word_t       rows[$];
    logic [CountW-1:0] wrap_plan[NumPhases];
    int unsigned       p;
    int unsigned       k;

    in_valid_i  = 1'b0;
    kind_i      = KindTick;
    slot_i      = '0;
    period_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    mismatches   = 0;
    replies_seen = 0;
    words_sent   = 0;
    fired_polls  = 0;
    full_hits    = 0;
    noslot_hits  = 0;
    wrap_events  = 0;
    no_idle      = 1'b0;
    tm_used       = 0;
    tm_wrap_limit = WrapLimitRst;
    for (k = 0; k < Slots; k++) begin
      tm_tick[k]    = '0;
      tm_last[k]    = '0;
      tm_resid[k]   = '0;
      tm_period[k]  = '0;
      tm_wrapped[k] = 1'b0;
      tm_flag[k]    = 1'b0;
    end

    // directed words, run with the wrap limit at its reset value
    rows.push_back(mk_row(KindPoll, 4'd0, '0, 1'b1, '0, 1'b0, StatNoSlot));
    rows.push_back(mk_row(KindTick, 4'd0, '1, 1'b1, '0, 1'b0, StatOk));
    rows.push_back(mk_row(KindBadLo, 4'd15, '1, 1'b1, '0, 1'b0, StatOk));
    rows.push_back(mk_row(KindBadLo + 3'd1, 4'd0, '0, 1'b1, '0, 1'b0, StatOk));
    rows.push_back(mk_row(KindBadHi, 4'd15, '1, 1'b1, '0, 1'b0, StatOk));
    rows.push_back(mk_row(KindRestart, 4'd3, '0, 1'b1, '0, 1'b0, StatNoSlot));
    rows.push_back(mk_row(KindClear, 4'd15, '0, 1'b1, '0, 1'b0, StatNoSlot));
    rows.push_back(mk_row(KindAlloc, 4'd15, '0, 1'b1, 4'd0, 1'b0, StatOk));
    rows.push_back(mk_row(KindTick, 4'd0, '0, 1'b1, '0, 1'b0, StatOk));
    // zero period fires on every tick, a poll clears the flag
    rows.push_back(mk_row(KindPoll, 4'd0, '0, 1'b1, '0, 1'b1, StatOk));
    rows.push_back(mk_row(KindPoll, 4'd0, '0, 1'b1, '0, 1'b0, StatOk));
    rows.push_back(mk_row(KindAlloc, 4'd0, '1, 1'b1, 4'd1, 1'b0, StatOk));
    rows.push_back(mk_row(KindPoll, 4'd1, '0, 1'b1, '0, 1'b0, StatOk));
    rows.push_back(mk_row(KindAlloc, 4'd7, 32'd1, 1'b1, 4'd2, 1'b0, StatOk));
    rows.push_back(mk_row(KindTick, 4'd0, '0, 1'b0, '0, 1'b0, StatOk));
    rows.push_back(mk_row(KindClear, 4'd0, '0, 1'b1, '0, 1'b0, StatOk));
    rows.push_back(mk_row(KindPoll, 4'd0, '0, 1'b1, '0, 1'b0, StatOk));
    rows.push_back(mk_row(KindPoll, 4'd2, '0, 1'b0, '0, 1'b0, StatOk));
    rows.push_back(mk_row(KindTick, 4'd0, '0, 1'b0, '0, 1'b0, StatOk));
    rows.push_back(mk_row(KindRestart, 4'd2, '0, 1'b1, '0, 1'b0, StatOk));
    rows.push_back(mk_row(KindPoll, 4'd2, '0, 1'b1, '0, 1'b0, StatOk));
    rows.push_back(mk_row(KindPoll, 4'd3, '0, 1'b1, '0, 1'b0, StatNoSlot));
    rows.push_back(mk_row(KindPoll, 4'd1, '0, 1'b0, '0, 1'b0, StatOk));

    wrap_plan[0] = 32'd1;
    wrap_plan[1] = 32'd0;
    wrap_plan[2] = 32'd7;
    wrap_plan[3] = CountW'($urandom_range(2, 40));
    wrap_plan[4] = WrapLimitRst;
    wrap_plan[5] = CountW'($urandom());

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[n]) begin
      send_word(rows[n]);
      idle_in(pick_gap());
    end

    for (p = 0; p < NumPhases; p++) begin
      settle();
      cfg_valid_i <= 1'b1;
      cfg_data_i  <= wrap_plan[p];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      cfg_valid_i   <= 1'b0;
      tm_wrap_limit = wrap_plan[p];
      for (k = 0; k < ItemsPerPhase; k++) begin
        if (k % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_word(random_word());
        idle_in(pick_gap());
      end
    end
    settle();

    $display("covered %0d words over %0d wrap limit settings, %0d replies checked",
             words_sent, NumPhases + 1, replies_seen);
    $display("%0d fired polls, %0d full allocates, %0d unallocated slots, %0d counter wraps",
             fired_polls, full_hits, noslot_hits, wrap_events);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/ptb_pkg.sv
src/ptb_mem.sv
src/ptb_adv.sv
src/periodic_timer_bank_core.sv
sim/periodic_timer_bank_core_tb.sv
